/* hdl/c3r_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the 3x3 convolution and ReLU stream core.
// Used by the line cells, the window cells and the top level; no dependencies.
package c3r_pkg;

    localparam int IMG_W      = 10;
    localparam int IMG_H      = 10;
    localparam int PIX_W      = 16;
    localparam int COEF_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int KROW_W     = 3 * COEF_W;
    localparam int PROD_W     = PIX_W + COEF_W;
    localparam int ROWSUM_W   = PROD_W + 2;
    localparam int SUM_W      = PROD_W + 4;
    localparam int RESULT_W   = 15;
    localparam int POS_W      = 3;
    localparam int COL_CNT_W  = $clog2(IMG_W);
    localparam int ROW_CNT_W  = $clog2(IMG_H);
    localparam int CFG_IDX_W  = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW2 = 2'd2;

    typedef logic signed [PIX_W-1:0]  pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

/* hdl/conv3x3_relu_stream_core.sv */
`timescale 1ns / 1ps
// Top level of the 3x3 convolution and ReLU stream core.
// Depends on c3r_pkg, c3r_line_cell and c3r_mac_cell.
//
// Pixels enter one per transfer in raster order and the core takes one pixel
// every clock cycle while the result side keeps up. One chain of 2*IMG_W line
// cells delays the stream by one and two image rows at its taps, and nine
// window cells multiply as the pixel arrives. A result is registered in turn
// as products, row sums, then the final sum with rectify and saturation in the
// output register. Pixels whose window is incomplete give no result and only
// move the line store and window; each stage holds its item while the next is full.
module conv3x3_relu_stream_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pixel
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [14:0] conv_value, [17:15] out_row, [20:18] out_col
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    typedef struct packed {
        logic [c3r_pkg::POS_W-1:0] row;
        logic [c3r_pkg::POS_W-1:0] col;
        logic                      last;
    } meta_t;

    localparam logic [c3r_pkg::COL_CNT_W-1:0] COL_LAST =
        c3r_pkg::COL_CNT_W'(c3r_pkg::IMG_W - 1);
    localparam logic [c3r_pkg::ROW_CNT_W-1:0] ROW_LAST =
        c3r_pkg::ROW_CNT_W'(c3r_pkg::IMG_H - 1);
    localparam logic [c3r_pkg::COL_CNT_W-1:0] COL_FIRST_OUT = c3r_pkg::COL_CNT_W'(2);
    localparam logic [c3r_pkg::ROW_CNT_W-1:0] ROW_FIRST_OUT = c3r_pkg::ROW_CNT_W'(2);
    localparam logic [c3r_pkg::RESULT_W-1:0]  RESULT_MAX = '1;

    // Configuration registers.
    logic [c3r_pkg::KROW_W-1:0] kernel_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg[0] <= '0;
            kernel_reg[1] <= '0;
            kernel_reg[2] <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                c3r_pkg::REG_KERNEL_ROW0: kernel_reg[0] <= cfg_data;
                c3r_pkg::REG_KERNEL_ROW1: kernel_reg[1] <= cfg_data;
                c3r_pkg::REG_KERNEL_ROW2: kernel_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake through the three stages.
    logic  v1_reg, v2_reg;
    logic  ready1, ready2, ready3;
    logic  accept;

    assign ready3   = !m_tvalid || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;
    assign accept   = s_tvalid && ready1;

    // Position counters.
    logic [c3r_pkg::COL_CNT_W-1:0] col_reg, col_next, col_cur;
    logic [c3r_pkg::ROW_CNT_W-1:0] row_reg, row_next, row_cur;
    logic  produce;
    meta_t meta_cur;

    always_comb begin
        col_cur = s_tuser ? '0 : col_reg;
        row_cur = s_tuser ? '0 : row_reg;
        produce = (row_cur >= ROW_FIRST_OUT) && (col_cur >= COL_FIRST_OUT);
        meta_cur.row  = c3r_pkg::POS_W'(row_cur - ROW_FIRST_OUT);
        meta_cur.col  = c3r_pkg::POS_W'(col_cur - COL_FIRST_OUT);
        meta_cur.last = (row_cur == ROW_LAST) && (col_cur == COL_LAST);
        if (col_cur >= COL_LAST) begin
            col_next = '0;
            row_next = (row_cur >= ROW_LAST) ? '0 : row_cur + c3r_pkg::ROW_CNT_W'(1);
        end else begin
            col_next = col_cur + c3r_pkg::COL_CNT_W'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line store: one chain of 2*IMG_W cells, tapped after one and two image rows.
    c3r_pkg::pix_t line_tap [2*c3r_pkg::IMG_W];
    c3r_pkg::pix_t col_pix [3];

    genvar gi, gm, gn;
    generate
        for (gi = 0; gi < 2 * c3r_pkg::IMG_W; gi++) begin : g_line
            if (gi == 0) begin : g_head
                c3r_line_cell u_cell (
                    .aclk    (aclk),
                    .shift_en(accept),
                    .pix_in  (c3r_pkg::pix_t'(s_tdata)),
                    .pix_out (line_tap[gi])
                );
            end else begin : g_body
                c3r_line_cell u_cell (
                    .aclk    (aclk),
                    .shift_en(accept),
                    .pix_in  (line_tap[gi-1]),
                    .pix_out (line_tap[gi])
                );
            end
        end
    endgenerate

    // Window row 0 is two rows back, row 2 is the incoming pixel.
    assign col_pix[0] = line_tap[2*c3r_pkg::IMG_W-1];
    assign col_pix[1] = line_tap[c3r_pkg::IMG_W-1];
    assign col_pix[2] = c3r_pkg::pix_t'(s_tdata);

    // Window cells: column 2 is the newest, column 0 the oldest.
    c3r_pkg::pix_t  win_pix [3][3];
    c3r_pkg::prod_t prod [3][3];

    generate
        for (gm = 0; gm < 3; gm++) begin : g_wrow
            for (gn = 0; gn < 3; gn++) begin : g_wcol
                c3r_pkg::pix_t win_in;
                if (gn == 2) begin : g_new
                    assign win_in = col_pix[gm];
                end else begin : g_old
                    assign win_in = win_pix[gm][gn+1];
                end
                c3r_mac_cell u_cell (
                    .aclk    (aclk),
                    .shift_en(accept),
                    .pix_in  (win_in),
                    .coef    (c3r_pkg::coef_t'(
                                  kernel_reg[gm][gn*c3r_pkg::COEF_W +: c3r_pkg::COEF_W])),
                    .pix_out (win_pix[gm][gn]),
                    .prod_out(prod[gm][gn])
                );
            end
        end
    endgenerate

    // Stage 1: products sit in the window cells.
    meta_t meta1_reg, meta2_reg, meta3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ready1) begin
            v1_reg <= accept && produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            meta1_reg <= meta_cur;
        end
    end

    // Stage 2: one sum per kernel row.
    logic signed [c3r_pkg::ROWSUM_W-1:0] row_sum_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ready2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && v1_reg) begin
            for (int m = 0; m < 3; m++) begin
                row_sum_reg[m] <= c3r_pkg::ROWSUM_W'(prod[m][0])
                                + c3r_pkg::ROWSUM_W'(prod[m][1])
                                + c3r_pkg::ROWSUM_W'(prod[m][2]);
            end
            meta2_reg <= meta1_reg;
        end
    end

    // Stage 3: full sum, rectify, drop the fraction, saturate.
    logic signed [c3r_pkg::SUM_W-1:0]          total;
    logic [c3r_pkg::SUM_W-c3r_pkg::FRAC_W-2:0] scaled;
    logic [c3r_pkg::RESULT_W-1:0]              value_next, value_reg;

    always_comb begin
        total = c3r_pkg::SUM_W'(row_sum_reg[0]) + c3r_pkg::SUM_W'(row_sum_reg[1])
              + c3r_pkg::SUM_W'(row_sum_reg[2]);
        scaled = total[c3r_pkg::SUM_W-2:c3r_pkg::FRAC_W];
        if (total[c3r_pkg::SUM_W-1]) begin
            value_next = '0;
        end else if (|scaled[$bits(scaled)-1:c3r_pkg::RESULT_W]) begin
            value_next = RESULT_MAX;
        end else begin
            value_next = scaled[c3r_pkg::RESULT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (ready3) begin
            m_tvalid <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready3 && v2_reg) begin
            value_reg <= value_next;
            meta3_reg <= meta2_reg;
        end
    end

    assign m_tdata = {3'b000, meta3_reg.col, meta3_reg.row, value_reg};
    assign m_tlast = meta3_reg.last;

`ifndef NO_ASSERTIONS
    // The position counters never leave the image.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= COL_LAST) && (row_reg <= ROW_LAST))
        else $error("position counter out of range");

    // A frame-start pixel leaves the position at row 0, column 1.
    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser) |=> (col_reg == c3r_pkg::COL_CNT_W'(1)) && (row_reg == '0))
        else $error("frame start did not restart the position");

    // The last result of a frame sits in the bottom-right corner of the map.
    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
            (m_tdata[17:15] == c3r_pkg::POS_W'(c3r_pkg::IMG_H - 3))
            && (m_tdata[20:18] == c3r_pkg::POS_W'(c3r_pkg::IMG_W - 3)))
        else $error("frame end flag away from the last output position");
`endif

endmodule

/* hdl/c3r_line_cell.sv */
`timescale 1ns / 1ps
// One pixel stage of the line store chain.
// Depends on c3r_pkg for the pixel type.
module c3r_line_cell (
    input  logic          aclk,
    input  logic          shift_en,
    input  c3r_pkg::pix_t pix_in,
    output c3r_pkg::pix_t pix_out
);

    c3r_pkg::pix_t pix_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            pix_reg <= pix_in;
        end
    end

    assign pix_out = pix_reg;

endmodule

/* hdl/c3r_mac_cell.sv */
`timescale 1ns / 1ps
// One tap of the 3x3 window: holds a pixel, hands it to the older neighbor,
// and registers the product of the incoming pixel and its coefficient. Uses c3r_pkg.
module c3r_mac_cell (
    input  logic           aclk,
    input  logic           shift_en,
    input  c3r_pkg::pix_t  pix_in,
    input  c3r_pkg::coef_t coef,
    output c3r_pkg::pix_t  pix_out,
    output c3r_pkg::prod_t prod_out
);

    c3r_pkg::pix_t  pix_reg;
    c3r_pkg::prod_t prod_reg;

    // The product is taken from the pixel entering the tap, so it matches
    // the window as it stands after this transfer.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            pix_reg  <= pix_in;
            prod_reg <= c3r_pkg::prod_t'(pix_in) * c3r_pkg::prod_t'(coef);
        end
    end

    assign pix_out  = pix_reg;
    assign prod_out = prod_reg;

endmodule
